>>> design/mlcd_pkg.sv
// Shared types, codes and helpers for the memory LCD SPI framer.
// Used by mlcd_ctrl, mlcd_dp and memory_lcd_spi_framer_top. No dependencies.
`default_nettype none

package mlcd_pkg;

    // Request type codes on the input channel.
    localparam logic [1:0] REQ_PIXEL  = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_STATIC = 2'd2;

    // Command bytes sent to the panel.
    localparam logic [7:0] CMD_WRITE = 8'h80;
    localparam logic [7:0] CMD_CLEAR = 8'h20;
    localparam logic [7:0] CMD_ZERO  = 8'h00;

    // Line counter width, fixed by the line address byte.
    localparam int LINE_W = 8;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OPEN,
        ST_ADDR,
        ST_DATA,
        ST_TRAIL,
        ST_FINAL,
        ST_CLR,
        ST_CLR_END,
        ST_STA0,
        ST_STA1,
        ST_STA2
    } state_t;

    // Source of the byte loaded into the output register.
    typedef enum logic [2:0] {
        SEL_WRITE,
        SEL_CLEAR,
        SEL_ZERO,
        SEL_ADDR,
        SEL_DATA
    } byte_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      accept;
        logic      push;
        byte_sel_t sel;
        logic      eot;
        logic      last;
        logic      ptr_dec;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic first_beat;
        logic line_done;
        logic frame_done;
        logic out_free;
        logic ptr_zero;
    } dp_stat_t;

    // Reverse the bit order of a byte.
    function automatic logic [7:0] bit_rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/mlcd_ctrl.sv
// Sequencing state machine for the memory LCD SPI framer.
// Depends on mlcd_pkg; drives mlcd_dp through command and status structs.
`default_nettype none

module mlcd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         req_type,
    input  wire mlcd_pkg::dp_stat_t stat,
    output mlcd_pkg::ctl_cmd_t      cmd
);
    import mlcd_pkg::*;

    state_t state_reg, state_next;
    logic   line_reg, line_next;
    logic   fin_reg, fin_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // State and latched line flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            line_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            line_reg  <= line_next;
            fin_reg   <= fin_next;
        end
    end

    // Next state: each emit state advances only when its beat is loaded.
    always_comb
    begin
        state_next = state_reg;
        line_next  = line_reg;
        fin_next   = fin_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    line_next = stat.line_done;
                    fin_next  = stat.frame_done;
                    case (req_type)
                        REQ_PIXEL:
                        begin
                            if (stat.first_beat)
                                state_next = ST_OPEN;
                            else if (stat.line_done)
                                state_next = ST_ADDR;
                            else
                                state_next = ST_IDLE;
                        end
                        REQ_CLEAR:  state_next = ST_CLR;
                        REQ_STATIC: state_next = ST_STA0;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OPEN:
            begin
                if (stat.out_free)
                    state_next = line_reg ? ST_ADDR : ST_IDLE;
            end
            ST_ADDR:
            begin
                if (stat.out_free)
                    state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (stat.out_free && stat.ptr_zero)
                    state_next = ST_TRAIL;
            end
            ST_TRAIL:
            begin
                if (stat.out_free)
                    state_next = fin_reg ? ST_FINAL : ST_IDLE;
            end
            ST_FINAL:   if (stat.out_free) state_next = ST_IDLE;
            ST_CLR:     if (stat.out_free) state_next = ST_CLR_END;
            ST_CLR_END: if (stat.out_free) state_next = ST_IDLE;
            ST_STA0:    if (stat.out_free) state_next = ST_STA1;
            ST_STA1:    if (stat.out_free) state_next = ST_STA2;
            ST_STA2:    if (stat.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Commands: which byte to load and how to mark it.
    always_comb
    begin
        cmd         = '0;
        cmd.sel     = SEL_ZERO;
        cmd.accept  = accept;
        case (state_reg)
            ST_IDLE: cmd.push = 1'b0;
            ST_OPEN:
            begin
                cmd.push = stat.out_free;
                cmd.sel  = SEL_WRITE;
                cmd.last = !line_reg;
            end
            ST_ADDR:
            begin
                cmd.push = stat.out_free;
                cmd.sel  = SEL_ADDR;
            end
            ST_DATA:
            begin
                cmd.push    = stat.out_free;
                cmd.sel     = SEL_DATA;
                cmd.ptr_dec = stat.out_free;
            end
            ST_TRAIL:
            begin
                cmd.push = stat.out_free;
                cmd.last = !fin_reg;
            end
            ST_FINAL, ST_CLR_END, ST_STA2:
            begin
                cmd.push = stat.out_free;
                cmd.eot  = 1'b1;
                cmd.last = 1'b1;
            end
            ST_CLR:
            begin
                cmd.push = stat.out_free;
                cmd.sel  = SEL_CLEAR;
            end
            ST_STA0, ST_STA1: cmd.push = stat.out_free;
            default: cmd.push = 1'b0;
        endcase
    end

`ifndef NO_ASSERTIONS
    // A beat is never loaded over one that has not been taken.
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> stat.out_free)
        else $error("beat loaded while output register is occupied");

    // A clear command starts its own transfer in the next cycle.
    a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == REQ_CLEAR) |=> state_reg == ST_CLR)
        else $error("clear command did not start its transfer");

    // The last line byte is followed by the trailer.
    a_data_trail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA && cmd.push && stat.ptr_zero) |=> state_reg == ST_TRAIL)
        else $error("line data not followed by trailer");

    // No new item is taken while a sequence is still being emitted.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !accept)
        else $error("item accepted during emission");
`endif

endmodule

`default_nettype wire

>>> design/mlcd_dp.sv
// Datapath of the memory LCD SPI framer: line memory, counters, output register.
// Depends on mlcd_pkg; controlled by mlcd_ctrl.
`default_nettype none

module mlcd_dp #(
    parameter int ROWS       = 168,
    parameter int LINE_BYTES = 18
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mlcd_pkg::ctl_cmd_t cmd,
    output mlcd_pkg::dp_stat_t      stat,
    input  wire logic [1:0]         req_type,
    input  wire logic [7:0]         pixel_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              spi_byte,
    output logic                    end_of_transfer,
    output logic                    last
);
    import mlcd_pkg::*;

    localparam int BW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam logic [BW-1:0]     LAST_BYTE = BW'(LINE_BYTES - 1);
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(ROWS - 1);
    localparam logic [LINE_W-1:0] ROWS_VAL  = LINE_W'(ROWS);

    logic [7:0]        line_mem [LINE_BYTES];
    logic [BW-1:0]     byte_idx_reg, byte_idx_next;
    logic [LINE_W-1:0] line_idx_reg, line_idx_next;
    logic [BW-1:0]     ptr_reg, ptr_next;
    logic [7:0]        rd_data_reg;
    logic [7:0]        addr_reg;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        byte_reg;
    logic              eot_reg;
    logic              last_reg;
    logic [7:0]        byte_mux;
    logic              pix_accept;

    assign pix_accept = cmd.accept && (req_type == REQ_PIXEL);

    // Status toward the controller.
    always_comb
    begin
        stat.first_beat = (byte_idx_reg == '0) && (line_idx_reg == '0);
        stat.line_done  = (byte_idx_reg == LAST_BYTE);
        stat.frame_done = (line_idx_reg == LAST_LINE);
        stat.out_free   = !out_valid_reg || out_ready;
        stat.ptr_zero   = (ptr_reg == '0);
    end

    // Position counters within the frame.
    always_comb
    begin
        byte_idx_next = byte_idx_reg;
        line_idx_next = line_idx_reg;
        if (cmd.accept)
        begin
            case (req_type)
                REQ_PIXEL:
                begin
                    if (stat.line_done)
                    begin
                        byte_idx_next = '0;
                        line_idx_next = stat.frame_done ? '0 : line_idx_reg + 1'b1;
                    end
                    else
                    begin
                        byte_idx_next = byte_idx_reg + 1'b1;
                    end
                end
                REQ_CLEAR, REQ_STATIC:
                begin
                    byte_idx_next = '0;
                    line_idx_next = '0;
                end
                default:
                begin
                    byte_idx_next = byte_idx_reg;
                    line_idx_next = line_idx_reg;
                end
            endcase
        end
    end

    // Read pointer walks the line from last byte to first.
    always_comb
    begin
        if (cmd.accept)
            ptr_next = LAST_BYTE;
        else if (cmd.ptr_dec && !stat.ptr_zero)
            ptr_next = ptr_reg - 1'b1;
        else
            ptr_next = ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg  <= '0;
            line_idx_reg  <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            byte_idx_reg  <= byte_idx_next;
            line_idx_reg  <= line_idx_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Line memory: one write port, one registered read port. The read is
    // refreshed every cycle, so data written at accept is seen before use.
    always_ff @(posedge clk)
    begin
        if (pix_accept)
            line_mem[byte_idx_reg] <= pixel_byte;
        rd_data_reg <= line_mem[ptr_next];
    end

    // Line address byte, captured with every pixel byte; the line's last byte sets the value sent.
    always_ff @(posedge clk)
    begin
        if (pix_accept)
            addr_reg <= bit_rev8(ROWS_VAL - line_idx_reg);
    end

    // Output byte selection.
    always_comb
    begin
        case (cmd.sel)
            SEL_WRITE: byte_mux = CMD_WRITE;
            SEL_CLEAR: byte_mux = CMD_CLEAR;
            SEL_ADDR:  byte_mux = addr_reg;
            SEL_DATA:  byte_mux = rd_data_reg;
            default:   byte_mux = CMD_ZERO;
        endcase
    end

    // Output register holds one beat until it is taken.
    always_comb
    begin
        if (cmd.push)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            byte_reg <= byte_mux;
            eot_reg  <= cmd.eot;
            last_reg <= cmd.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign spi_byte        = byte_reg;
    assign end_of_transfer = eot_reg;
    assign last            = last_reg;

endmodule

`default_nettype wire

>>> design/memory_lcd_spi_framer_top.sv
// Top level of the memory LCD SPI framer.
// Depends on mlcd_pkg, mlcd_ctrl and mlcd_dp.
`default_nettype none

// Takes pixel bytes in raster order (LINE_BYTES per line, ROWS lines per frame),
// or a clear or static command, and produces the panel's SPI byte stream, one
// byte per output beat, with end_of_transfer on the byte after which chip
// select is released and last on the final beat caused by each input beat.
// A pixel byte inside a line is only stored; the first byte of a frame also
// emits the write command. The byte that completes a line emits the line
// address, the line's bytes and a trailer (plus a final zero on the frame's
// last line, and the write command first if it also opens the frame), as the
// controller loads one output byte per cycle while the output is not stalled
// and the line is read back through the line memory's single registered read
// port one byte per cycle. Clear emits its command and a zero, static three
// zeros. A new input beat is taken once the last byte of the previous is loaded.

module memory_lcd_spi_framer_top #(
    parameter int ROWS       = 168,
    parameter int LINE_BYTES = 18
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] req_type,
    input  wire logic [7:0] pixel_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      spi_byte,
    output logic            end_of_transfer,
    output logic            last
);
    import mlcd_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    mlcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd)
    );

    mlcd_dp #(
        .ROWS       (ROWS),
        .LINE_BYTES (LINE_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_type        (req_type),
        .pixel_byte      (pixel_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .spi_byte        (spi_byte),
        .end_of_transfer (end_of_transfer),
        .last            (last)
    );

endmodule

`default_nettype wire
